// ----- rtl/oust_pkg.sv -----
// Shared types and codes for the ordered unique set table.
package oust_pkg;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_CHK,
    S_SCAN_CMP,
    S_SHIFT_CHK,
    S_SHIFT_WR,
    S_FINISH
  } state_e;

  localparam int unsigned PosW = 4;
  localparam int unsigned CntOutW = 5;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [PosW-1:0]    position;
    logic [CntOutW-1:0] entry_count;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic rd_en;
    logic rd_next;
    logic mark_hit;
    logic idx_inc;
    logic shift_wr;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op_known;
    logic is_remove;
    logic at_end;
    logic match;
    logic last_shift;
  } sts_t;

endpackage

// ----- rtl/oust_ctrl.sv -----
// Controller state machine sequencing scan, shift-down and completion.
module oust_ctrl
  import oust_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        state_d = (!sts_i.op_known || sts_i.at_end) ? S_FINISH : S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (sts_i.match) begin
          state_d = sts_i.is_remove ? S_SHIFT_CHK : S_FINISH;
        end else begin
          state_d = S_SCAN_CHK;
        end
      end
      S_SHIFT_CHK: begin
        state_d = sts_i.last_shift ? S_FINISH : S_SHIFT_WR;
      end
      S_SHIFT_WR: state_d = S_SHIFT_CHK;
      S_FINISH:   state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load = start_i;
      end
      S_SCAN_CHK: begin
        cmd_o.rd_en = sts_i.op_known && !sts_i.at_end;
      end
      S_SCAN_CMP: begin
        cmd_o.mark_hit = sts_i.match;
        cmd_o.idx_inc  = !sts_i.match;
      end
      S_SHIFT_CHK: begin
        cmd_o.rd_en   = !sts_i.last_shift;
        cmd_o.rd_next = !sts_i.last_shift;
      end
      S_SHIFT_WR: begin
        cmd_o.shift_wr = 1'b1;
        cmd_o.idx_inc  = 1'b1;
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ----- rtl/oust_dp.sv -----
// Datapath: entry memory, scan index, entry count and result register.
module oust_dp
  import oust_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t req_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [31:0]     mem_q [CAPACITY];
  logic [31:0]     rd_data_q;
  logic [31:0]     key_q;
  logic [1:0]      op_q;
  logic [CntW-1:0] idx_q, idx_nxt;
  logic [CntW-1:0] count_q, count_d;
  logic            hit_q;
  logic [IdxW-1:0] hit_pos_q;
  logic            done_q;
  rsp_t            rsp_q, rsp_d;

  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  logic [31:0]     wdata;
  logic            add_ok;
  logic [IdxW+PosW-1:0]    hit_ext, cnt_pos_ext;
  logic [CntW+CntOutW-1:0] cnt_ext;

  assign idx_nxt = idx_q + CntW'(1);

  assign sts_o.op_known   = (op_q == OP_LOOKUP) || (op_q == OP_ADD) || (op_q == OP_REMOVE);
  assign sts_o.is_remove  = (op_q == OP_REMOVE);
  assign sts_o.at_end     = (idx_q == count_q);
  assign sts_o.match      = (rd_data_q == key_q);
  assign sts_o.last_shift = (idx_nxt >= count_q);

  assign add_ok = (op_q == OP_ADD) && !hit_q && (count_q != CntW'(CAPACITY));
  assign raddr  = cmd_i.rd_next ? idx_nxt[IdxW-1:0] : idx_q[IdxW-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = idx_q[IdxW-1:0];
    wdata = rd_data_q;
    if (cmd_i.shift_wr) begin
      we = 1'b1;
    end else if (cmd_i.finish && add_ok) begin
      we    = 1'b1;
      waddr = count_q[IdxW-1:0];
      wdata = key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (cmd_i.rd_en) rd_data_q <= mem_q[raddr];
  end

  // Result fields wrap at their port widths when the capacity is large.
  assign hit_ext     = {{PosW{1'b0}}, hit_pos_q};
  assign cnt_pos_ext = {{PosW{1'b0}}, count_q[IdxW-1:0]};

  always_comb begin
    count_d      = count_q;
    rsp_d.status = ST_ABSENT;
    rsp_d.position = '0;
    case (op_q)
      OP_LOOKUP: begin
        if (hit_q) begin
          rsp_d.status   = ST_OK;
          rsp_d.position = hit_ext[PosW-1:0];
        end
      end
      OP_ADD: begin
        if (hit_q) begin
          rsp_d.position = hit_ext[PosW-1:0];
        end else if (!add_ok) begin
          rsp_d.status = ST_FULL;
        end else begin
          rsp_d.status   = ST_OK;
          rsp_d.position = cnt_pos_ext[PosW-1:0];
          count_d        = count_q + CntW'(1);
        end
      end
      OP_REMOVE: begin
        if (hit_q) begin
          rsp_d.status   = ST_OK;
          rsp_d.position = hit_ext[PosW-1:0];
          count_d        = count_q - CntW'(1);
        end
      end
      default: rsp_d.status = ST_ABSENT;
    endcase
    cnt_ext = {{CntOutW{1'b0}}, count_d};
    rsp_d.entry_count = cnt_ext[CntOutW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      hit_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
      if (cmd_i.finish) count_q <= count_d;
      if (cmd_i.load) begin
        hit_q <= 1'b0;
      end else if (cmd_i.mark_hit) begin
        hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= req_i.value;
      op_q  <= req_i.func;
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_nxt;
    end
    if (cmd_i.mark_hit) hit_pos_q <= idx_q[IdxW-1:0];
    if (cmd_i.finish) rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ----- rtl/ordered_unique_set_table_unit.sv -----
// Top level of the ordered unique set table: controller plus datapath.
//
// A request (func, value) is taken at a rising edge where start is high and
// busy is low. busy then stays high until the request has finished; the block
// holds one request at a time.
// The single response (status, position, entry_count) is marked by done_o,
// high for exactly one cycle; rsp_o holds it until the next response. The
// receiver cannot hold it off.
// The scan over the entry memory, whose one read port gives registered data,
// reads and compares one entry at a time; on a remove that matches, each
// later entry is then read and written one place down.
// done_o goes high as busy falls. A new request
// may start in the cycle where done_o is high.
// Reset clears the entry count, so the table starts empty; the entry memory
// itself is not cleared, since only entries below the count are ever read.
module ordered_unique_set_table_unit
  import oust_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  cmd_t cmd;
  sts_t sts;

  oust_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  oust_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  // A response only ever closes a transaction that was in progress.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("response without a transaction in progress");

  // An accepted transaction keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy did not rise after accepting a transaction");

  // A full-table response never carries a position.
  a_full_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.status == ST_FULL)) |-> (rsp_o.position == '0))
    else $error("full response with nonzero position");

  // The response strobe lasts exactly one cycle.
  a_no_done_while_busy_twice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("response strobe held for more than one cycle");

endmodule

// ----- tb/sv/ordered_unique_set_table_unit_tb.sv -----
// Self-checking testbench for the ordered unique set table unit.
module ordered_unique_set_table_unit_tb;
  import oust_pkg::*;

  localparam int unsigned TableDepth = 16;
  localparam logic [1:0] FuncUnused = 2'd3;
  localparam int unsigned RandItems = 900;
  localparam int unsigned PoolSize = 24;
  localparam int unsigned DrainCycles = 2 * TableDepth + 8;
  localparam int unsigned ReportLimit = 10;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic done_o;
  rsp_t rsp_o;

  ordered_unique_set_table_unit #(
    .CAPACITY(TableDepth)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  // One line of directed stimulus. A row with reps above one issues that many
  // requests with consecutive values; typed rows carry a hand-written result.
  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] value;
    logic [4:0]  reps;
    logic        typed;
    rsp_t        rsp;
  } dir_row_t;

  // Shadow copy of the table contents and entry count.
  logic signed [31:0] tbl_mem [TableDepth];
  int unsigned tbl_count = 0;

  rsp_t expected_q [$];

  int unsigned err_cnt = 0;
  int unsigned checked_cnt = 0;
  int unsigned full_cnt = 0;
  int unsigned peak_count = 0;
  int unsigned idle_pct = 0;
  int unsigned op_cnt [4] = '{0, 0, 0, 0};
  logic signed [31:0] key_pool [PoolSize];

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("timeout: %0d results still outstanding", expected_q.size());
    $display("ordered_unique_set_table_unit_tb: done, errors");
    $finish;
  end

  task automatic flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= ReportLimit) begin
      $display("ERROR: %s", msg);
    end
  endtask

  // Applies one request to the shadow table and returns the result it gives.
  function automatic rsp_t table_apply(input req_t rq);
    rsp_t rs;
    int hit;
    rs.status = ST_ABSENT;
    rs.position = '0;
    hit = -1;
    for (int i = 0; i < int'(tbl_count); i++) begin
      if (hit < 0 && tbl_mem[i] == rq.value) begin
        hit = i;
      end
    end
    case (rq.func)
      OP_LOOKUP: begin
        if (hit >= 0) begin
          rs.status = ST_OK;
          rs.position = PosW'(hit);
        end
      end
      OP_ADD: begin
        if (hit >= 0) begin
          rs.position = PosW'(hit);
        end else if (tbl_count >= TableDepth) begin
          rs.status = ST_FULL;
          full_cnt++;
        end else begin
          tbl_mem[tbl_count] = rq.value;
          rs.position = PosW'(tbl_count);
          rs.status = ST_OK;
          tbl_count++;
          if (tbl_count > peak_count) begin
            peak_count = tbl_count;
          end
        end
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          // Later entries close the gap so insertion order is kept.
          for (int i = hit; i + 1 < int'(tbl_count); i++) begin
            tbl_mem[i] = tbl_mem[i + 1];
          end
          tbl_count--;
          rs.status = ST_OK;
          rs.position = PosW'(hit);
        end
      end
      default: begin
      end
    endcase
    rs.entry_count = CntOutW'(tbl_count);
    return rs;
  endfunction

  // Presents one request, after an optional idle gap, and waits for the
  // transaction to be taken. Returns in the time step of acceptance without
  // having driven anything in it.
  task automatic send_request(input req_t rq, input logic typed, input rsp_t typed_rsp);
    rsp_t rs;
    if (idle_pct != 0 && $urandom_range(19) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(40, 1)) @(posedge clk_i);
    end
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= rq;
    do @(posedge clk_i); while (busy !== 1'b0);
    rs = table_apply(rq);
    op_cnt[rq.func]++;
    if (typed) begin
      rs = typed_rsp;
    end
    expected_q = {expected_q, rs};
  endtask

  always @(posedge clk_i) begin : result_check
    rsp_t want;
    if (done_o === 1'b1) begin
      if (expected_q.size() == 0) begin
        flag_error($sformatf("unexpected result: status %0d position %0d count %0d",
                             rsp_o.status, rsp_o.position, rsp_o.entry_count));
      end else begin
        want = expected_q.pop_front();
        checked_cnt++;
        if (rsp_o.status !== want.status || rsp_o.position !== want.position ||
            rsp_o.entry_count !== want.entry_count) begin
          flag_error($sformatf({"result %0d: expected status %0d position %0d count %0d,",
                                " got status %0d position %0d count %0d"},
                               checked_cnt, want.status, want.position,
                               want.entry_count, rsp_o.status, rsp_o.position,
                               rsp_o.entry_count));
        end
      end
    end
  end

  initial begin
    dir_row_t dir_rows [12];
    req_t rq;
    int unsigned mode;
    int unsigned pick;
    int unsigned add_cut;
    int unsigned rem_cut;

    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;

    dir_rows = '{
      '{OP_LOOKUP,  32'h0000_0000, 5'd1,  1'b1, '{ST_ABSENT, 4'd0,  5'd0}},
      '{OP_REMOVE,  32'h0000_0000, 5'd1,  1'b1, '{ST_ABSENT, 4'd0,  5'd0}},
      '{OP_ADD,     32'h8000_0000, 5'd1,  1'b1, '{ST_OK,     4'd0,  5'd1}},
      '{OP_ADD,     32'h7FFF_FFFF, 5'd1,  1'b1, '{ST_OK,     4'd1,  5'd2}},
      '{OP_LOOKUP,  32'h7FFF_FFFF, 5'd1,  1'b1, '{ST_OK,     4'd1,  5'd2}},
      '{FuncUnused, 32'hFFFF_FFFF, 5'd1,  1'b1, '{ST_ABSENT, 4'd0,  5'd2}},
      '{OP_REMOVE,  32'h8000_0000, 5'd1,  1'b1, '{ST_OK,     4'd0,  5'd1}},
      '{OP_ADD,     32'hFFFF_FFF0, 5'd15, 1'b0, '0},
      '{OP_ADD,     32'h0000_0000, 5'd1,  1'b1, '{ST_FULL,   4'd0,  5'd16}},
      '{OP_ADD,     32'hFFFF_FFF5, 5'd1,  1'b1, '{ST_ABSENT, 4'd6,  5'd16}},
      '{OP_REMOVE,  32'h7FFF_FFFF, 5'd1,  1'b1, '{ST_OK,     4'd0,  5'd15}},
      '{OP_REMOVE,  32'hFFFF_FFFE, 5'd1,  1'b1, '{ST_OK,     4'd14, 5'd14}}
    };

    // A small key pool makes hits, duplicates and a full table common.
    key_pool[0] = 32'sh0000_0000;
    key_pool[1] = -32'sd1;
    key_pool[2] = 32'sh8000_0000;
    key_pool[3] = 32'sh7FFF_FFFF;
    for (int i = 4; i < int'(PoolSize); i++) begin
      key_pool[i] = $urandom;
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 29;
    foreach (dir_rows[r]) begin
      for (int k = 0; k < int'(dir_rows[r].reps); k++) begin
        rq.func = dir_rows[r].func;
        rq.value = dir_rows[r].value + k;
        send_request(rq, dir_rows[r].typed, dir_rows[r].rsp);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      // Hold the next request back until every outstanding result is in.
      start <= 1'b0;
      do @(posedge clk_i); while (expected_q.size() != 0);
      idle_pct = (ph == 0) ? 29 : (ph == 1) ? 75 : 0;
      for (int n = 0; n < int'(RandItems / 3); n++) begin
        // Blocks of requests lean toward filling, churning or draining the table.
        if (n % 100 == 0) begin
          mode = $urandom_range(2);
        end
        case (mode)
          0: begin add_cut = 60; rem_cut = 75; end
          1: begin add_cut = 35; rem_cut = 65; end
          default: begin add_cut = 15; rem_cut = 65; end
        endcase
        pick = $urandom_range(99);
        rq.func = (pick < add_cut) ? OP_ADD : (pick < rem_cut) ? OP_REMOVE :
                  (pick < 95) ? OP_LOOKUP : FuncUnused;
        rq.value = ($urandom_range(4) != 0) ? key_pool[$urandom_range(PoolSize - 1)]
                                             : $urandom;
        send_request(rq, 1'b0, '0);
      end
    end

    start <= 1'b0;
    do @(posedge clk_i); while (expected_q.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);

    if (expected_q.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", expected_q.size()));
    end
    $display("covered %0d requests: %0d lookups, %0d adds, %0d removes, %0d unused selectors",
             op_cnt[0] + op_cnt[1] + op_cnt[2] + op_cnt[3], op_cnt[OP_LOOKUP],
             op_cnt[OP_ADD], op_cnt[OP_REMOVE], op_cnt[FuncUnused]);
    $display("%0d results checked, table peaked at %0d entries, %0d adds refused as full",
             checked_cnt, peak_count, full_cnt);
    if (err_cnt == 0) begin
      $display("ordered_unique_set_table_unit_tb: done, clean");
    end else begin
      $display("%0d errors", err_cnt);
      $display("ordered_unique_set_table_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
